### hdl/spc_pkg.sv
`timescale 1ns / 1ps

package spc_pkg;

	// Number of character states handled by the lanes (2 to 4).
	localparam int STATE_COUNT = 4;
	// Width of one cost value; the all-ones pattern stands for infinity (16 to 32).
	localparam int COST_BITS   = 32;
	// Fixed layout of the ports and of the transition cost registers.
	localparam int LANES       = 4;
	localparam int PORT_BITS   = 32;
	localparam int TRANS_BITS  = 16;
	localparam int ROW_BITS    = LANES * TRANS_BITS;
	localparam int WEIGHT_BITS = 16;
	localparam int SCORE_BITS  = 48;
	localparam int CFG_IDX_BITS = 2;
	localparam int PROD_BITS   = COST_BITS + WEIGHT_BITS;

	typedef logic [COST_BITS-1:0]   cost_t;
	typedef logic [TRANS_BITS-1:0]  trans_t;
	typedef logic [ROW_BITS-1:0]    row_t;
	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [SCORE_BITS-1:0]  score_t;
	typedef logic [PORT_BITS-1:0]   port_cost_t;
	typedef logic [PROD_BITS-1:0]   prod_t;

	typedef cost_t  [STATE_COUNT-1:0] cost_vec_t;
	typedef trans_t [STATE_COUNT-1:0] trans_col_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COST_ROW_0 = 2'd0,
		REG_COST_ROW_1 = 2'd1,
		REG_COST_ROW_2 = 2'd2,
		REG_COST_ROW_3 = 2'd3
	} cfg_reg_t;

	localparam cost_t COST_INF = {COST_BITS{1'b1}};

	localparam row_t ROW_RESET [LANES] = '{
		64'h0001_0001_0001_0000,
		64'h0001_0001_0000_0001,
		64'h0001_0000_0001_0001,
		64'h0000_0001_0001_0001
	};

	// Stage advance strobes for the lane stages.
	typedef struct packed {
		logic s1;
		logic s2;
	} lane_ctl_t;

	// Stage advance strobes for the merge stages.
	typedef struct packed {
		logic s3;
		logic s4;
	} merge_ctl_t;

	// Addition that sticks at infinity once either operand or the sum reaches it.
	function automatic cost_t sat_add(cost_t a, cost_t b);
		logic [COST_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (a == COST_INF || b == COST_INF || sum >= {1'b0, COST_INF}) begin
			return COST_INF;
		end
		return sum[COST_BITS-1:0];
	endfunction

endpackage

### hdl/spc_in_if.sv
`timescale 1ns / 1ps

interface spc_in_if;
	import spc_pkg::*;

	logic       valid;
	logic       ready;
	port_cost_t first_cost_0;
	port_cost_t first_cost_1;
	port_cost_t first_cost_2;
	port_cost_t first_cost_3;
	port_cost_t second_cost_0;
	port_cost_t second_cost_1;
	port_cost_t second_cost_2;
	port_cost_t second_cost_3;
	logic       second_present;
	weight_t    pattern_weight;
	logic       constant_pattern;

	modport source (
		output valid, first_cost_0, first_cost_1, first_cost_2, first_cost_3,
		       second_cost_0, second_cost_1, second_cost_2, second_cost_3,
		       second_present, pattern_weight, constant_pattern,
		input  ready
	);

	modport sink (
		input  valid, first_cost_0, first_cost_1, first_cost_2, first_cost_3,
		       second_cost_0, second_cost_1, second_cost_2, second_cost_3,
		       second_present, pattern_weight, constant_pattern,
		output ready
	);

endinterface

### hdl/spc_out_if.sv
`timescale 1ns / 1ps

interface spc_out_if;
	import spc_pkg::*;

	logic       valid;
	logic       ready;
	port_cost_t parent_cost_0;
	port_cost_t parent_cost_1;
	port_cost_t parent_cost_2;
	port_cost_t parent_cost_3;
	port_cost_t min_cost;
	score_t     weighted_score;

	modport source (
		output valid, parent_cost_0, parent_cost_1, parent_cost_2, parent_cost_3,
		       min_cost, weighted_score,
		input  ready
	);

	modport sink (
		input  valid, parent_cost_0, parent_cost_1, parent_cost_2, parent_cost_3,
		       min_cost, weighted_score,
		output ready
	);

endinterface

### hdl/spc_lane.sv
`timescale 1ns / 1ps

// Parent state: best cost per child; saturated sum if both present.
module spc_lane import spc_pkg::*; (
	input  logic       clk,
	input  lane_ctl_t  ctl,
	input  cost_vec_t  first_cost,
	input  cost_vec_t  second_cost,
	input  trans_col_t trans_col,
	input  logic       second_present,
	input  logic       constant_pattern,
	output cost_t      parent_s2
);

	cost_t best_first_s1;
	cost_t best_second_s1;
	logic  two_s1;
	logic  const_s1;
	cost_t best_first;
	cost_t best_second;

	always_comb begin
		cost_t cf;
		cost_t cs;
		best_first  = COST_INF;
		best_second = COST_INF;
		for (int j = 0; j < STATE_COUNT; j++) begin
			cf = sat_add(first_cost[j], cost_t'(trans_col[j]));
			cs = sat_add(second_cost[j], cost_t'(trans_col[j]));
			if (j == 0 || cf < best_first) begin
				best_first = cf;
			end
			if (j == 0 || cs < best_second) begin
				best_second = cs;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.s1) begin
			best_first_s1  <= best_first;
			best_second_s1 <= best_second;
			two_s1         <= second_present;
			const_s1       <= constant_pattern;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.s2) begin
			if (const_s1) begin
				parent_s2 <= '0;
			end else if (two_s1) begin
				parent_s2 <= sat_add(best_first_s1, best_second_s1);
			end else begin
				parent_s2 <= best_first_s1;
			end
		end
	end

endmodule

### hdl/spc_merge.sv
`timescale 1ns / 1ps

// Minimum over the lanes, then the weighted score.
module spc_merge import spc_pkg::*; (
	input  logic       clk,
	input  merge_ctl_t ctl,
	input  cost_vec_t  parent_s2,
	input  weight_t    weight_s2,
	output cost_vec_t  parent_s4,
	output cost_t      min_s4,
	output score_t     score_s4
);

	cost_vec_t parent_s3;
	cost_t     min_s3;
	weight_t   weight_s3;
	cost_t     min_all;
	prod_t     product;

	always_comb begin
		min_all = parent_s2[0];
		for (int i = 1; i < STATE_COUNT; i++) begin
			if (parent_s2[i] < min_all) begin
				min_all = parent_s2[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.s3) begin
			parent_s3 <= parent_s2;
			min_s3    <= min_all;
			weight_s3 <= weight_s2;
		end
	end

	// The product of a cost and a weight always fits the score field.
	assign product = prod_t'(min_s3) * prod_t'(weight_s3);

	always_ff @(posedge clk) begin
		if (ctl.s4) begin
			parent_s4 <= parent_s3;
			min_s4    <= min_s3;
			score_s4  <= score_t'(product);
		end
	end

endmodule

### hdl/sankoff_parsimony_combine_unit.sv
`timescale 1ns / 1ps

// Sankoff parsimony combine unit: one pattern transfer in, one result transfer out,
// at a rate of one item per clock cycle while the result side takes every result.
// The pipe has four register stages, and the result is offered from the last.
// One lane per parent state adds the transition costs to each child's costs and
// takes the minimum over child states in the first stage, then sums the two
// children with saturation in the second when both are present; a merge stage
// takes the minimum over the parent states in the third and forms the 32 by 16
// bit weighted score in the fourth, which is also the output register. Each stage
// holds its item only while the stages behind it are full and stalled, so a waiting
// result does not keep new patterns out until the whole pipe has filled. The
// all-ones cost means infinity, and every addition sticks there. A constant
// pattern gives all zeros. The four transition cost rows come up with zero on the
// diagonal and one elsewhere, and the user must write them through the write port
// only while the unit is idle; the unit itself does not enforce this.
module sankoff_parsimony_combine_unit import spc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  row_t                    cfg_data,
	spc_in_if.sink                  pattern,
	spc_out_if.source               result
);

	row_t       cost_row_q [LANES];
	cost_vec_t  first_cost;
	cost_vec_t  second_cost;
	cost_vec_t  parent_s2;
	cost_vec_t  parent_s4;
	cost_t      min_s4;
	score_t     score_s4;
	weight_t    weight_s1;
	weight_t    weight_s2;
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       valid_s4;
	logic       ready_s1;
	logic       ready_s2;
	logic       ready_s3;
	logic       ready_s4;
	lane_ctl_t  lane_ctl;
	merge_ctl_t merge_ctl;
	port_cost_t first_port [LANES];
	port_cost_t second_port [LANES];
	port_cost_t parent_port [LANES];

	// Transition cost rows. Row j holds the costs from state j, one 16-bit lane per
	// target state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANES; k++) begin
				cost_row_q[k] <= ROW_RESET[k];
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COST_ROW_0: cost_row_q[0] <= cfg_data;
				REG_COST_ROW_1: cost_row_q[1] <= cfg_data;
				REG_COST_ROW_2: cost_row_q[2] <= cfg_data;
				REG_COST_ROW_3: cost_row_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when the stage after it moves on.
	assign ready_s4 = !valid_s4 || result.ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pattern.ready = ready_s1;

	assign lane_ctl.s1  = ready_s1;
	assign lane_ctl.s2  = ready_s2;
	assign merge_ctl.s3 = ready_s3;
	assign merge_ctl.s4 = ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pattern.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// The pattern weight rides alongside the lanes until the merge stage takes it.
	always_ff @(posedge clk) begin
		if (ready_s1) begin
			weight_s1 <= pattern.pattern_weight;
		end
		if (ready_s2) begin
			weight_s2 <= weight_s1;
		end
	end

	assign first_port[0]  = pattern.first_cost_0;
	assign first_port[1]  = pattern.first_cost_1;
	assign first_port[2]  = pattern.first_cost_2;
	assign first_port[3]  = pattern.first_cost_3;
	assign second_port[0] = pattern.second_cost_0;
	assign second_port[1] = pattern.second_cost_1;
	assign second_port[2] = pattern.second_cost_2;
	assign second_port[3] = pattern.second_cost_3;

	// Child costs are taken in their low cost bits; states beyond the configured
	// count are simply not wired into the lanes.
	always_comb begin
		for (int j = 0; j < STATE_COUNT; j++) begin
			first_cost[j]  = first_port[j][COST_BITS-1:0];
			second_cost[j] = second_port[j][COST_BITS-1:0];
		end
	end

	for (genvar i = 0; i < STATE_COUNT; i++) begin : g_lane
		trans_col_t trans_col;

		// Column i of the matrix: the cost from every state j into parent state i.
		always_comb begin
			for (int j = 0; j < STATE_COUNT; j++) begin
				trans_col[j] = cost_row_q[j][i*TRANS_BITS +: TRANS_BITS];
			end
		end

		spc_lane u_lane (
			.clk              (clk),
			.ctl              (lane_ctl),
			.first_cost       (first_cost),
			.second_cost      (second_cost),
			.trans_col        (trans_col),
			.second_present   (pattern.second_present),
			.constant_pattern (pattern.constant_pattern),
			.parent_s2        (parent_s2[i])
		);
	end

	spc_merge u_merge (
		.clk       (clk),
		.ctl       (merge_ctl),
		.parent_s2 (parent_s2),
		.weight_s2 (weight_s2),
		.parent_s4 (parent_s4),
		.min_s4    (min_s4),
		.score_s4  (score_s4)
	);

	// Parent costs of states beyond the configured count read as zero.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			parent_port[i] = '0;
		end
		for (int i = 0; i < STATE_COUNT; i++) begin
			parent_port[i] = port_cost_t'(parent_s4[i]);
		end
	end

	assign result.valid          = valid_s4;
	assign result.parent_cost_0  = parent_port[0];
	assign result.parent_cost_1  = parent_port[1];
	assign result.parent_cost_2  = parent_port[2];
	assign result.parent_cost_3  = parent_port[3];
	assign result.min_cost       = port_cost_t'(min_s4);
	assign result.weighted_score = score_s4;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the Sankoff parsimony combine unit.
//
// Patterns go in on one valid/ready channel and parent cost vectors come back on
// another, one result per pattern and in order. Every accepted input transfer
// queues the result it must produce, and every accepted output transfer is
// compared field by field with the oldest queued result. The bench keeps its own
// copy of the four transition cost rows so the prediction always uses the
// setting that was loaded when the pattern went in.
//
// The run starts with a hand-written list of patterns under the reset costs. Where
// the answer is obvious the expected result is typed into the list; the other rows
// use the predictor. Then come five phases of random patterns, each under its own
// cost setting: random rows, all zero, all at the 16-bit maximum, small typical
// costs, and the reset values written back. Cost rows are only loaded after every
// queued result has come back and the pipe has had time to empty.
module testbench;
	import spc_pkg::*;

	// The unit offers a result once its pattern has passed through the pipe, so this
	// many idle cycles is plenty before a cost write or before the final verdict.
	localparam int SETTLE_CYCLES  = 12;
	localparam int ITEMS_PER_RUN  = 220;
	// The long output stall that makes the pipe fill and push back on the input.
	localparam int HOLD_CYCLES    = 80;
	localparam int RESET_CYCLES   = 11;

	localparam cfg_reg_t ROW_REGS [LANES] = '{
		REG_COST_ROW_0, REG_COST_ROW_1, REG_COST_ROW_2, REG_COST_ROW_3
	};

	typedef enum int {ROWS_RANDOM, ROWS_ZERO, ROWS_MAX, ROWS_SMALL, ROWS_RESET} row_setting_t;
	typedef enum int {SPREAD_SMALL, SPREAD_HIGH, SPREAD_ANY} cost_spread_t;

	typedef row_t [LANES-1:0] row_set_t;

	typedef struct packed {
		port_cost_t [LANES-1:0] first;
		port_cost_t [LANES-1:0] second;
		logic                   second_present;
		weight_t                weight;
		logic                   constant_pattern;
	} pat_t;

	typedef struct packed {
		port_cost_t [LANES-1:0] parent;
		port_cost_t             min_cost;
		score_t                 score;
	} res_t;

	typedef struct packed {
		pat_t stim;
		logic typed;
		res_t want;
	} directed_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	row_t                    cfg_data;

	spc_in_if  pattern_ch ();
	spc_out_if result_ch ();

	sankoff_parsimony_combine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pattern   (pattern_ch),
		.result    (result_ch)
	);

	// The bench's copy of the transition cost registers.
	row_t cost_rows [LANES];
	// Results owed by the unit, oldest first.
	res_t pending_results [$];
	int   mismatches;
	// Set by the stimulus to ask the output side for its long stall.
	bit   hold_off_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Addition that sticks at the all-ones cost once anything reaches it.
	function automatic cost_t add_clamped(cost_t a, logic [63:0] b);
		logic [63:0] sum;
		sum = 64'(a) + b;
		if (a == COST_INF || b >= 64'(COST_INF) || sum >= 64'(COST_INF)) begin
			return COST_INF;
		end
		return cost_t'(sum);
	endfunction

	// Cheapest way for one child to reach parent state 'to'.
	function automatic cost_t best_move(port_cost_t [LANES-1:0] child, int to);
		cost_t best;
		cost_t c;
		best = COST_INF;
		for (int j = 0; j < STATE_COUNT; j++) begin
			c = add_clamped(cost_t'(child[j]), 64'(cost_rows[j][TRANS_BITS*to +: TRANS_BITS]));
			if (j == 0 || c < best) begin
				best = c;
			end
		end
		return best;
	endfunction

	function automatic res_t combine_costs(pat_t p);
		res_t        r;
		cost_t       par;
		cost_t       lowest;
		logic [63:0] product;
		r = '0;
		lowest = '0;
		// A constant pattern contributes nothing, so everything stays zero.
		if (!p.constant_pattern) begin
			for (int i = 0; i < STATE_COUNT; i++) begin
				par = best_move(p.first, i);
				if (p.second_present) begin
					par = add_clamped(par, 64'(best_move(p.second, i)));
				end
				r.parent[i] = port_cost_t'(par);
				if (i == 0 || par < lowest) begin
					lowest = par;
				end
			end
			r.min_cost = port_cost_t'(lowest);
			product = 64'(lowest) * 64'(p.weight);
			if (product > 64'({SCORE_BITS{1'b1}})) begin
				r.score = '1;
			end else begin
				r.score = product[SCORE_BITS-1:0];
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic pat_t pattern_of(port_cost_t f0, port_cost_t f1, port_cost_t f2,
			port_cost_t f3, port_cost_t s0, port_cost_t s1, port_cost_t s2, port_cost_t s3,
			logic two, weight_t w, logic cst);
		pat_t p;
		p.first  = {f3, f2, f1, f0};
		p.second = {s3, s2, s1, s0};
		p.second_present   = two;
		p.weight           = w;
		p.constant_pattern = cst;
		return p;
	endfunction

	function automatic res_t result_of(port_cost_t p0, port_cost_t p1, port_cost_t p2,
			port_cost_t p3, port_cost_t m, score_t s);
		res_t r;
		r.parent   = {p3, p2, p1, p0};
		r.min_cost = m;
		r.score    = s;
		return r;
	endfunction

	// Mostly back to back, sometimes a short gap, rarely a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	function automatic port_cost_t random_cost(cost_spread_t spread);
		int pick;
		pick = $urandom_range(0, 9);
		case (spread)
			SPREAD_SMALL: begin
				return $urandom_range(0, 200);
			end
			SPREAD_HIGH: begin
				// Near infinity, or near half of it so that two children overflow.
				if (pick < 3) begin
					return COST_INF;
				end else if (pick < 6) begin
					return COST_INF - $urandom_range(0, 32'h3_FFFF);
				end
				return $urandom_range(32'h7FFF_0000, 32'h8001_0000);
			end
			default: begin
				if (pick == 0) begin
					return '0;
				end else if (pick == 1) begin
					return COST_INF;
				end else if (pick < 4) begin
					return $urandom_range(0, 1000);
				end else if (pick == 4) begin
					return COST_INF - $urandom_range(0, 32'hFFFF);
				end
				return $urandom;
			end
		endcase
	endfunction

	function automatic pat_t random_pattern();
		pat_t         p;
		cost_spread_t spread;
		int           pick;
		spread = cost_spread_t'($urandom_range(0, 2));
		for (int j = 0; j < LANES; j++) begin
			p.first[j]  = random_cost(spread);
			p.second[j] = random_cost(spread);
		end
		p.second_present = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			p.weight = '0;
		end else if (pick == 1) begin
			p.weight = '1;
		end else begin
			p.weight = weight_t'($urandom);
		end
		p.constant_pattern = ($urandom_range(0, 11) == 0);
		return p;
	endfunction

	// Offers one pattern and returns at the edge where it is taken. The valid
	// stays high on return, so a following call with no gap keeps it high.
	task automatic offer_pattern(input pat_t p, input logic typed, input res_t want,
			input bit allow_gaps);
		int gap;
		gap = allow_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			pattern_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pattern_ch.first_cost_0     <= p.first[0];
		pattern_ch.first_cost_1     <= p.first[1];
		pattern_ch.first_cost_2     <= p.first[2];
		pattern_ch.first_cost_3     <= p.first[3];
		pattern_ch.second_cost_0    <= p.second[0];
		pattern_ch.second_cost_1    <= p.second[1];
		pattern_ch.second_cost_2    <= p.second[2];
		pattern_ch.second_cost_3    <= p.second[3];
		pattern_ch.second_present   <= p.second_present;
		pattern_ch.pattern_weight   <= p.weight;
		pattern_ch.constant_pattern <= p.constant_pattern;
		pattern_ch.valid            <= 1'b1;
		do @(posedge clk); while (pattern_ch.ready !== 1'b1);
		pending_results.push_back(typed ? want : combine_costs(p));
	endtask

	// Waits until every owed result is back, then lets the pipe settle.
	task automatic drain_results();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Loads all four cost rows one after another; only called while idle.
	task automatic load_cost_rows(input row_set_t rows);
		drain_results();
		for (int k = 0; k < LANES; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= ROW_REGS[k];
			cfg_data  <= rows[k];
			cost_rows[k] = rows[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Output side: random back-pressure plus one long hold-off.
	// ------------------------------------------------------------------
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				// The input keeps offering patterns during this stretch, so the
				// pipe fills and the unit has to drop its input ready.
				hold_off_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		res_t got;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			got = result_of(result_ch.parent_cost_0, result_ch.parent_cost_1,
				result_ch.parent_cost_2, result_ch.parent_cost_3, result_ch.min_cost,
				result_ch.weighted_score);
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result transfer with nothing expected, got min_cost 0x%0h",
					$time, got.min_cost);
			end else begin
				want = pending_results.pop_front();
				compare_field("parent_cost_0", 64'(want.parent[0]), 64'(got.parent[0]));
				compare_field("parent_cost_1", 64'(want.parent[1]), 64'(got.parent[1]));
				compare_field("parent_cost_2", 64'(want.parent[2]), 64'(got.parent[2]));
				compare_field("parent_cost_3", 64'(want.parent[3]), 64'(got.parent[3]));
				compare_field("min_cost", 64'(want.min_cost), 64'(got.min_cost));
				compare_field("weighted_score", 64'(want.score), 64'(got.score));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		directed_row_t directed_rows [$];
		row_set_t      rows;
		row_setting_t  setting;

		mismatches   = 0;
		hold_off_req = 1'b0;
		for (int k = 0; k < LANES; k++) begin
			cost_rows[k] = ROW_RESET[k];
		end

		arst_n                       <= 1'b0;
		cfg_we                       <= 1'b0;
		cfg_index                    <= REG_COST_ROW_0;
		cfg_data                     <= '0;
		pattern_ch.valid             <= 1'b0;
		pattern_ch.first_cost_0      <= '0;
		pattern_ch.first_cost_1      <= '0;
		pattern_ch.first_cost_2      <= '0;
		pattern_ch.first_cost_3      <= '0;
		pattern_ch.second_cost_0     <= '0;
		pattern_ch.second_cost_1     <= '0;
		pattern_ch.second_cost_2     <= '0;
		pattern_ch.second_cost_3     <= '0;
		pattern_ch.second_present    <= 1'b0;
		pattern_ch.pattern_weight    <= '0;
		pattern_ch.constant_pattern  <= 1'b0;

		// Directed list, all under the reset costs: zero on the diagonal, one
		// elsewhere. A typed row carries its answer; the rest use the predictor.
		// All zero costs give all zero results.
		directed_rows.push_back('{pattern_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 16'd1, 1'b0),
			1'b1, result_of(0, 0, 0, 0, 0, 48'd0)});
		// Constant pattern: everything zero whatever the costs say.
		directed_rows.push_back('{pattern_of(7, 3, 9, 1, 2, 4, 6, 8, 1'b1, 16'hFFFF, 1'b1),
			1'b1, result_of(0, 0, 0, 0, 0, 48'd0)});
		directed_rows.push_back('{pattern_of(COST_INF, COST_INF, COST_INF, COST_INF,
			COST_INF, COST_INF, COST_INF, COST_INF, 1'b1, 16'hFFFF, 1'b1),
			1'b1, result_of(0, 0, 0, 0, 0, 48'd0)});
		// An infinite child stays infinite, and the largest score fits in 48 bits.
		directed_rows.push_back('{pattern_of(COST_INF, COST_INF, COST_INF, COST_INF,
			0, 0, 0, 0, 1'b0, 16'hFFFF, 1'b0),
			1'b1, result_of(COST_INF, COST_INF, COST_INF, COST_INF, COST_INF,
			48'hFFFE_FFFF_0001)});
		// Two children with flat costs add lane by lane.
		directed_rows.push_back('{pattern_of(5, 5, 5, 5, 7, 7, 7, 7, 1'b1, 16'd3, 1'b0),
			1'b1, result_of(12, 12, 12, 12, 12, 48'd36)});
		// Overflow: two costs just below infinity sum to infinity.
		directed_rows.push_back('{pattern_of(COST_INF - 1, COST_INF - 1, COST_INF - 1,
			COST_INF - 1, COST_INF - 1, COST_INF - 1, COST_INF - 1, COST_INF - 1, 1'b1,
			16'd2, 1'b0),
			1'b1, result_of(COST_INF, COST_INF, COST_INF, COST_INF, COST_INF,
			48'h1_FFFF_FFFE)});
		// A sum that lands exactly on the all-ones value counts as infinity.
		directed_rows.push_back('{pattern_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			1'b1, 16'd1, 1'b0),
			1'b1, result_of(COST_INF, COST_INF, COST_INF, COST_INF, COST_INF,
			48'hFFFF_FFFF)});
		// Infinity plus a zero child is still infinity.
		directed_rows.push_back('{pattern_of(COST_INF, COST_INF, COST_INF, COST_INF,
			0, 0, 0, 0, 1'b1, 16'd1, 1'b0),
			1'b1, result_of(COST_INF, COST_INF, COST_INF, COST_INF, COST_INF,
			48'hFFFF_FFFF)});
		// Second child absent: its infinite costs must be ignored.
		directed_rows.push_back('{pattern_of(0, 0, 0, 0, COST_INF, COST_INF, COST_INF,
			COST_INF, 1'b0, 16'hFFFF, 1'b0),
			1'b1, result_of(0, 0, 0, 0, 0, 48'd0)});
		// One finite entry: it reaches its own state free and the others at one.
		directed_rows.push_back('{pattern_of(0, COST_INF, COST_INF, COST_INF, 0, 0, 0, 0,
			1'b0, 16'hFFFF, 1'b0),
			1'b1, result_of(0, 1, 1, 1, 0, 48'd0)});
		// Distinct costs with zero weight.
		directed_rows.push_back('{pattern_of(10, 20, 30, 40, 0, 0, 0, 0, 1'b0, 16'd0, 1'b0),
			1'b1, result_of(10, 11, 11, 11, 10, 48'd0)});
		// The remaining rows go through the predictor.
		directed_rows.push_back('{pattern_of(32'hAAAA_AAAA, 32'h5555_5555, COST_INF - 1, 1,
			32'h5555_5555, 32'hAAAA_AAAA, 1, COST_INF - 1, 1'b1, 16'hAAAA, 1'b0), 1'b0, '0});
		directed_rows.push_back('{pattern_of(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			1'b1, 16'h5555, 1'b0), 1'b0, '0});
		directed_rows.push_back('{pattern_of(100, 3, 50, 9, COST_INF, 0, COST_INF, 2,
			1'b1, 16'h8001, 1'b0), 1'b0, '0});
		directed_rows.push_back('{pattern_of(COST_INF, COST_INF, COST_INF, 42, 1, 2, 3, 4,
			1'b0, 16'h1234, 1'b0), 1'b0, '0});
		directed_rows.push_back('{pattern_of(32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FFFD,
			32'h1234_5678, 32'h8765_4321, COST_INF, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
			1'b1, 16'h7FFF, 1'b0), 1'b0, '0});

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			offer_pattern(directed_rows[n].stim, directed_rows[n].typed,
				directed_rows[n].want, 1'b1);
		end
		pattern_ch.valid <= 1'b0;

		// Random phases, each under a fresh cost setting. The first thirty items
		// of every hundred are offered back to back, which gives stretches with
		// no idling on the input side.
		for (int s = 0; s < 5; s++) begin
			setting = row_setting_t'(s);
			for (int k = 0; k < LANES; k++) begin
				case (setting)
					ROWS_RANDOM: rows[k] = {$urandom, $urandom};
					ROWS_ZERO:   rows[k] = '0;
					ROWS_MAX:    rows[k] = '1;
					ROWS_SMALL: begin
						for (int t = 0; t < LANES; t++) begin
							rows[k][TRANS_BITS*t +: TRANS_BITS] =
								(t == k) ? '0 : trans_t'($urandom_range(1, 7));
						end
					end
					default:     rows[k] = ROW_RESET[k];
				endcase
			end
			load_cost_rows(rows);
			for (int n = 0; n < ITEMS_PER_RUN; n++) begin
				if (setting == ROWS_RANDOM && n == 0) begin
					hold_off_req = 1'b1;
				end
				offer_pattern(random_pattern(), 1'b0, '0, (n % 100) >= 30);
			end
			pattern_ch.valid <= 1'b0;
		end

		drain_results();
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** sankoff_parsimony_combine_unit: PASSED **");
		end else begin
			$display("** sankoff_parsimony_combine_unit: FAILED **");
		end
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("** sankoff_parsimony_combine_unit: FAILED **");
		$finish;
	end

endmodule
